// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the core RTL, used by rsti_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RSTI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define RSTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define RSTI_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RSTI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/rsti_pkg.sv =====
package rsti_pkg;

    localparam int RADIX_BITS = 6;
    localparam int CHAR_BITS  = 8;
    localparam int OUT_BITS   = 64;

    localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_BITS-1:0] RADIX_HEX   = 6'd16;
    localparam logic [RADIX_BITS-1:0] RADIX_BIN   = 6'd2;
    localparam logic [RADIX_BITS-1:0] ALPHA_BASE  = 6'd10;

    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_BITS-1:0] CH_LB    = 8'h62;
    localparam logic [CHAR_BITS-1:0] CH_UB    = 8'h42;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EMIT
    } ctl_state_t;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_PREFIX,
        PH_ZERO,
        PH_DIGITS,
        PH_STOP
    } phase_t;

    typedef struct packed {
        logic capture;
        logic set_neg;
        logic commit;
        logic saturate;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic has_char;
        logic last;
        logic is_space;
        logic is_plus;
        logic is_minus;
        logic is_zero;
        logic prefix_base;
        logic prefix_mark;
        logic digit_ok;
        logic ovf;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/core/rsti_if.sv =====
interface rsti_in_if;
    logic                             valid;
    logic                             ready;
    logic [rsti_pkg::CHAR_BITS-1:0]   char_code;
    logic                             has_char;
    logic                             last;

    modport source (output valid, output char_code, output has_char, output last, input ready);
    modport sink (input valid, input char_code, input has_char, input last, output ready);
endinterface

interface rsti_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [rsti_pkg::OUT_BITS-1:0] value;
    logic                                overflowed;

    modport source (output valid, output value, output overflowed, input ready);
    modport sink (input valid, input value, input overflowed, output ready);
endinterface

// ===== rtl/core/rsti_dpath.sv =====
module rsti_dpath #(
    parameter int VALUE_BITS = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [rsti_pkg::RADIX_BITS-1:0]       cfg_data,
    input  logic [rsti_pkg::CHAR_BITS-1:0]        in_char_code,
    input  logic                                  in_has_char,
    input  logic                                  in_last,
    input  logic                                  out_ready,
    input  rsti_pkg::cmd_t                        cmd,
    output rsti_pkg::status_t                     status,
    output logic                                  out_valid,
    output logic signed [rsti_pkg::OUT_BITS-1:0]  out_value,
    output logic                                  out_overflowed
);

    localparam int PROD_BITS = VALUE_BITS + rsti_pkg::RADIX_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam logic [VALUE_BITS-1:0] MAX_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] MIN_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};

    logic [rsti_pkg::RADIX_BITS-1:0] radix_reg;
    logic [rsti_pkg::CHAR_BITS-1:0]  char_reg;
    logic                            has_char_reg;
    logic                            last_reg;
    logic [VALUE_BITS-1:0]           mag_reg;
    logic [VALUE_BITS-1:0]           mag_next;
    logic                            neg_reg;
    logic                            neg_next;
    logic                            sat_reg;
    logic                            sat_next;
    logic [PROD_BITS-1:0]            prod_reg;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic signed [rsti_pkg::OUT_BITS-1:0] out_value_reg;
    logic                            out_ovf_reg;

    logic [rsti_pkg::RADIX_BITS-1:0] digit;
    logic                            is_digit_char;
    logic                            radix_ok;
    logic [SUM_BITS-1:0]             sum;
    logic [SUM_BITS-1:0]             limit;
    logic signed [VALUE_BITS-1:0]    result;

    always_comb
    begin
        digit         = '0;
        is_digit_char = 1'b0;
        if (char_reg >= rsti_pkg::CH_0 && char_reg <= rsti_pkg::CH_9)
        begin
            digit         = rsti_pkg::RADIX_BITS'(char_reg - rsti_pkg::CH_0);
            is_digit_char = 1'b1;
        end
        else if (char_reg >= rsti_pkg::CH_LA && char_reg <= rsti_pkg::CH_LZ)
        begin
            digit         = rsti_pkg::RADIX_BITS'(char_reg - rsti_pkg::CH_LA)
                            + rsti_pkg::ALPHA_BASE;
            is_digit_char = 1'b1;
        end
        else if (char_reg >= rsti_pkg::CH_UA && char_reg <= rsti_pkg::CH_UZ)
        begin
            digit         = rsti_pkg::RADIX_BITS'(char_reg - rsti_pkg::CH_UA)
                            + rsti_pkg::ALPHA_BASE;
            is_digit_char = 1'b1;
        end
    end

    assign radix_ok = (radix_reg >= rsti_pkg::RADIX_MIN) && (radix_reg <= rsti_pkg::RADIX_MAX);
    assign sum      = SUM_BITS'(prod_reg) + SUM_BITS'(digit);
    assign limit    = SUM_BITS'(MAX_POS) + SUM_BITS'(neg_reg);

    always_comb
    begin
        status.has_char    = has_char_reg;
        status.last        = last_reg;
        status.is_space    = (char_reg == rsti_pkg::CH_SPACE) || (char_reg == rsti_pkg::CH_TAB)
                             || (char_reg == rsti_pkg::CH_LF) || (char_reg == rsti_pkg::CH_CR);
        status.is_plus     = (char_reg == rsti_pkg::CH_PLUS);
        status.is_minus    = (char_reg == rsti_pkg::CH_MINUS);
        status.is_zero     = (char_reg == rsti_pkg::CH_0);
        status.prefix_base = (radix_reg == rsti_pkg::RADIX_HEX)
                             || (radix_reg == rsti_pkg::RADIX_BIN);
        status.prefix_mark = ((radix_reg == rsti_pkg::RADIX_HEX)
                              && ((char_reg == rsti_pkg::CH_LX) || (char_reg == rsti_pkg::CH_UX)))
                             || ((radix_reg == rsti_pkg::RADIX_BIN)
                              && ((char_reg == rsti_pkg::CH_LB) || (char_reg == rsti_pkg::CH_UB)));
        status.digit_ok    = radix_ok && is_digit_char && (digit < radix_reg);
        status.ovf         = sum > limit;
        status.out_free    = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        if (sat_reg)
        begin
            result = neg_reg ? MIN_NEG : MAX_POS;
        end
        else
        begin
            result = neg_reg ? (VALUE_BITS'(0) - mag_reg) : mag_reg;
        end
    end

    always_comb
    begin
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.set_neg)
        begin
            neg_next = 1'b1;
        end
        if (cmd.commit)
        begin
            mag_next = sum[VALUE_BITS-1:0];
        end
        if (cmd.saturate)
        begin
            sat_next = 1'b1;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            mag_next       = '0;
            neg_next       = 1'b0;
            sat_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= rsti_pkg::RADIX_RESET;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                radix_reg <= cfg_data;
            end
            mag_reg       <= mag_next;
            neg_reg       <= neg_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            char_reg     <= in_char_code;
            has_char_reg <= in_has_char;
            last_reg     <= in_last;
            prod_reg     <= PROD_BITS'(mag_reg) * PROD_BITS'(radix_reg);
        end
        if (cmd.emit)
        begin
            out_value_reg <= rsti_pkg::OUT_BITS'(result);
            out_ovf_reg   <= sat_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_value      = out_value_reg;
    assign out_overflowed = out_ovf_reg;

endmodule

// ===== rtl/core/rsti_ctrl.sv =====
`include "assert_macros.svh"

module rsti_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rsti_pkg::status_t status,
    output rsti_pkg::cmd_t    cmd
);

    rsti_pkg::ctl_state_t state_reg;
    rsti_pkg::ctl_state_t state_next;
    rsti_pkg::phase_t     phase_reg;
    rsti_pkg::phase_t     phase_next;

    logic act_neg;
    logic act_commit;
    logic act_sat;

    always_comb
    begin
        logic digit_step;
        digit_step = 1'b0;
        phase_next = phase_reg;
        act_neg    = 1'b0;
        act_commit = 1'b0;
        act_sat    = 1'b0;
        if (state_reg == rsti_pkg::ST_EXEC && status.has_char)
        begin
            unique case (phase_reg)
                rsti_pkg::PH_SPACE:
                begin
                    if (status.is_space)
                    begin
                        phase_next = rsti_pkg::PH_SPACE;
                    end
                    else if (status.is_plus || status.is_minus)
                    begin
                        phase_next = rsti_pkg::PH_PREFIX;
                        act_neg    = status.is_minus;
                    end
                    else if (status.is_zero && status.prefix_base)
                    begin
                        phase_next = rsti_pkg::PH_ZERO;
                    end
                    else
                    begin
                        digit_step = 1'b1;
                    end
                end
                rsti_pkg::PH_PREFIX:
                begin
                    if (status.is_zero && status.prefix_base)
                    begin
                        phase_next = rsti_pkg::PH_ZERO;
                    end
                    else
                    begin
                        digit_step = 1'b1;
                    end
                end
                rsti_pkg::PH_ZERO:
                begin
                    if (status.prefix_mark)
                    begin
                        phase_next = rsti_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        digit_step = 1'b1;
                    end
                end
                rsti_pkg::PH_DIGITS:
                begin
                    digit_step = 1'b1;
                end
                rsti_pkg::PH_STOP:
                begin
                    phase_next = rsti_pkg::PH_STOP;
                end
                default:
                begin
                    phase_next = rsti_pkg::PH_STOP;
                end
            endcase
            if (digit_step)
            begin
                if (!status.digit_ok)
                begin
                    phase_next = rsti_pkg::PH_STOP;
                end
                else if (status.ovf)
                begin
                    phase_next = rsti_pkg::PH_STOP;
                    act_sat    = 1'b1;
                end
                else
                begin
                    phase_next = rsti_pkg::PH_DIGITS;
                    act_commit = 1'b1;
                end
            end
        end
        if (state_reg == rsti_pkg::ST_EMIT && status.out_free)
        begin
            phase_next = rsti_pkg::PH_SPACE;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rsti_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rsti_pkg::ST_EXEC;
                end
            end
            rsti_pkg::ST_EXEC:
            begin
                state_next = status.last ? rsti_pkg::ST_EMIT : rsti_pkg::ST_IDLE;
            end
            rsti_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = rsti_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rsti_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = (state_reg == rsti_pkg::ST_IDLE);
        cmd.capture  = in_valid && (state_reg == rsti_pkg::ST_IDLE);
        cmd.set_neg  = act_neg;
        cmd.commit   = act_commit;
        cmd.saturate = act_sat;
        cmd.emit     = (state_reg == rsti_pkg::ST_EMIT) && status.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rsti_pkg::ST_IDLE;
            phase_reg <= rsti_pkg::PH_SPACE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    `RSTI_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, cmd.capture, state_reg == rsti_pkg::ST_EXEC)
    `RSTI_ASSERT_NEXT(a_emit_rewinds, clk, rst_n, cmd.emit, phase_reg == rsti_pkg::PH_SPACE)
    `RSTI_ASSERT_IMPL(a_stop_no_commit, clk, rst_n, phase_reg == rsti_pkg::PH_STOP, !cmd.commit)
    `RSTI_ASSERT_IMPL(a_single_action, clk, rst_n, cmd.commit || cmd.saturate, state_reg == rsti_pkg::ST_EXEC && !(cmd.commit && cmd.saturate))

endmodule

// ===== rtl/core/radix_string_to_integer_core.sv =====
// Converts a string, one character per transfer on the input channel, into a
// signed integer in the base held in the radix register (2 to 36).
// Input channel: char_code, has_char (0 marks an item with no character) and
// last (final item of the string). Output channel: value (sign-extended to 64
// bits, saturated on overflow) and overflowed; one transfer per string, made
// after the item marked last.
// For each item, the accept cycle registers the character and the product of the
// running magnitude and the radix, and the next cycle adds the digit and checks
// the result against the signed limit; no new item is accepted meanwhile. An
// item marked last then waits in the emit state until the output register is
// free and loads it; no new item is accepted until its result is loaded.
// The output register lets the next string start while a result waits; if the
// receiver stalls, the block holds the following last item until the
// previous result transfers.
// Reset clears the string state, empties the output and sets the radix to 10.
// The radix may be written only while no string is in progress.
module radix_string_to_integer_core #(
    parameter int VALUE_BITS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rsti_pkg::RADIX_BITS-1:0]     cfg_data,
    rsti_in_if.sink                             in,
    rsti_out_if.source                          out
);

    rsti_pkg::cmd_t    cmd;
    rsti_pkg::status_t status;
    logic              in_ready;
    logic              out_valid;
    logic signed [rsti_pkg::OUT_BITS-1:0] out_value;
    logic              out_overflowed;

    rsti_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rsti_dpath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .in_char_code   (in.char_code),
        .in_has_char    (in.has_char),
        .in_last        (in.last),
        .out_ready      (out.ready),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .out_value      (out_value),
        .out_overflowed (out_overflowed)
    );

    assign in.ready       = in_ready;
    assign out.valid      = out_valid;
    assign out.value      = out_value;
    assign out.overflowed = out_overflowed;

endmodule

// ===== dv/radix_string_to_integer_core_tb.sv =====
module radix_string_to_integer_core_tb;

    localparam int VALUE_BITS = 64;
    localparam logic [63:0] POS_MAX = (64'd1 << (VALUE_BITS - 1)) - 64'd1;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int RESET_CYCLES = 11;
    localparam int PHASES = 15;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int REPORT_CAP = 100;

    typedef struct packed {
        logic [rsti_pkg::CHAR_BITS-1:0] code;
        logic                           has_char;
        logic                           last;
    } char_item_t;

    typedef struct packed {
        logic signed [rsti_pkg::OUT_BITS-1:0] value;
        logic                                 overflowed;
    } conv_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [rsti_pkg::RADIX_BITS-1:0] cfg_data;

    rsti_in_if  char_ch ();
    rsti_out_if result_ch ();

    radix_string_to_integer_core #(
        .VALUE_BITS(VALUE_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in       (char_ch),
        .out      (result_ch)
    );

    char_item_t   pending_chars[$];
    conv_result_t expected_results[$];

    int send_idle_pct;
    int recv_idle_pct;
    int error_count = 0;
    int idle_cycles = 0;
    int item_count = 0;

    rsti_pkg::phase_t                conv_phase;
    logic                            conv_negative;
    logic [63:0]                     conv_magnitude;
    logic                            conv_saturated;
    logic [rsti_pkg::RADIX_BITS-1:0] conv_radix;

    logic [rsti_pkg::RADIX_BITS-1:0] radix_plan [PHASES] = '{
        rsti_pkg::RADIX_RESET, rsti_pkg::RADIX_BIN, rsti_pkg::RADIX_HEX, rsti_pkg::RADIX_MAX,
        6'd0, 6'd8, rsti_pkg::RADIX_HEX, rsti_pkg::RADIX_BIN, 6'd63, 6'd37,
        6'd1, 6'd3, rsti_pkg::RADIX_MAX, rsti_pkg::RADIX_RESET, 6'd0
    };

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void clear_string();
        conv_phase     = rsti_pkg::PH_SPACE;
        conv_negative  = 1'b0;
        conv_magnitude = 64'd0;
        conv_saturated = 1'b0;
    endfunction

    function automatic void take_digit(logic [rsti_pkg::CHAR_BITS-1:0] c);
        logic [63:0] digit;
        logic [63:0] limit;
        logic [63:0] base;
        base = 64'(conv_radix);
        if (conv_radix < rsti_pkg::RADIX_MIN || conv_radix > rsti_pkg::RADIX_MAX)
        begin
            conv_phase = rsti_pkg::PH_STOP;
            return;
        end
        if (c >= rsti_pkg::CH_0 && c <= rsti_pkg::CH_9)
            digit = 64'(c - rsti_pkg::CH_0);
        else if (c >= rsti_pkg::CH_LA && c <= rsti_pkg::CH_LZ)
            digit = 64'(c - rsti_pkg::CH_LA) + 64'(rsti_pkg::ALPHA_BASE);
        else if (c >= rsti_pkg::CH_UA && c <= rsti_pkg::CH_UZ)
            digit = 64'(c - rsti_pkg::CH_UA) + 64'(rsti_pkg::ALPHA_BASE);
        else
        begin
            conv_phase = rsti_pkg::PH_STOP;
            return;
        end
        if (digit >= base)
        begin
            conv_phase = rsti_pkg::PH_STOP;
            return;
        end
        limit = POS_MAX + (conv_negative ? 64'd1 : 64'd0);
        if (conv_magnitude > (limit - digit) / base)
        begin
            conv_saturated = 1'b1;
            conv_phase     = rsti_pkg::PH_STOP;
            return;
        end
        conv_magnitude = conv_magnitude * base + digit;
        conv_phase     = rsti_pkg::PH_DIGITS;
    endfunction

    function automatic void take_char(logic [rsti_pkg::CHAR_BITS-1:0] c);
        if (conv_phase == rsti_pkg::PH_SPACE)
        begin
            if (c == rsti_pkg::CH_SPACE || c == rsti_pkg::CH_TAB || c == rsti_pkg::CH_LF
                || c == rsti_pkg::CH_CR)
                return;
            conv_phase = rsti_pkg::PH_PREFIX;
            if (c == rsti_pkg::CH_PLUS || c == rsti_pkg::CH_MINUS)
            begin
                conv_negative = (c == rsti_pkg::CH_MINUS);
                return;
            end
        end
        if (conv_phase == rsti_pkg::PH_PREFIX)
        begin
            if (c == rsti_pkg::CH_0 && (conv_radix == rsti_pkg::RADIX_HEX
                                        || conv_radix == rsti_pkg::RADIX_BIN))
            begin
                conv_phase = rsti_pkg::PH_ZERO;
                return;
            end
            take_digit(c);
            return;
        end
        if (conv_phase == rsti_pkg::PH_ZERO)
        begin
            if ((conv_radix == rsti_pkg::RADIX_HEX
                 && (c == rsti_pkg::CH_LX || c == rsti_pkg::CH_UX)) ||
                (conv_radix == rsti_pkg::RADIX_BIN
                 && (c == rsti_pkg::CH_LB || c == rsti_pkg::CH_UB)))
            begin
                conv_phase = rsti_pkg::PH_DIGITS;
                return;
            end
            take_digit(c);
            return;
        end
        if (conv_phase == rsti_pkg::PH_DIGITS)
            take_digit(c);
    endfunction

    function automatic void predict_transfer(char_item_t item);
        conv_result_t r;
        if (item.has_char)
            take_char(item.code);
        if (item.last)
        begin
            if (conv_saturated)
                r.value = conv_negative ? ~POS_MAX : POS_MAX;
            else
                r.value = conv_negative ? 64'd0 - conv_magnitude : conv_magnitude;
            r.overflowed = conv_saturated;
            expected_results.push_back(r);
            clear_string();
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (error_count < REPORT_CAP)
            $display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
        error_count++;
    endtask

    task automatic check_result(logic [63:0] got_value, logic got_ovf);
        conv_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result with no string pending", got_value, 64'd0);
            return;
        end
        want = expected_results.pop_front();
        if (got_value !== want.value)
            report_mismatch("value", got_value, want.value);
        if (got_ovf !== want.overflowed)
            report_mismatch("overflowed", 64'(got_ovf), 64'(want.overflowed));
    endtask

    // drive the character channel; advance only on a transfer or an empty slot
    always @(posedge clk or negedge rst_n)
    begin : char_driver
        char_item_t next_item;
        if (!rst_n)
        begin
            char_ch.valid     <= 1'b0;
            char_ch.char_code <= '0;
            char_ch.has_char  <= 1'b0;
            char_ch.last      <= 1'b0;
        end
        else if (!char_ch.valid || char_ch.ready)
        begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_item = pending_chars.pop_front();
                char_ch.valid     <= 1'b1;
                char_ch.char_code <= next_item.code;
                char_ch.has_char  <= next_item.has_char;
                char_ch.last      <= next_item.last;
            end
            else
                char_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // check the result transfer first so a new expectation never matches it
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
                check_result(result_ch.value, result_ch.overflowed);
            if (char_ch.valid && char_ch.ready)
                predict_transfer(char_item_t'{char_ch.char_code, char_ch.has_char,
                                              char_ch.last});
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_ch.valid && char_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles == STALL_LIMIT)
            begin
                $display("radix_string_to_integer_core_tb: errors");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [rsti_pkg::CHAR_BITS-1:0] digit_char(int d);
        if (d < int'(rsti_pkg::ALPHA_BASE))
            return rsti_pkg::CH_0 + 8'(d);
        if ($urandom_range(1) == 1)
            return rsti_pkg::CH_LA + 8'(d - int'(rsti_pkg::ALPHA_BASE));
        return rsti_pkg::CH_UA + 8'(d - int'(rsti_pkg::ALPHA_BASE));
    endfunction

    function automatic logic [rsti_pkg::CHAR_BITS-1:0] pick_space();
        case ($urandom_range(3))
            0: return rsti_pkg::CH_SPACE;
            1: return rsti_pkg::CH_TAB;
            2: return rsti_pkg::CH_LF;
            default: return rsti_pkg::CH_CR;
        endcase
    endfunction

    function automatic logic [rsti_pkg::CHAR_BITS-1:0] pick_marked();
        case ($urandom_range(9))
            0: return pick_space();
            1: return rsti_pkg::CH_PLUS;
            2: return rsti_pkg::CH_MINUS;
            3: return rsti_pkg::CH_0;
            4: return $urandom_range(1) ? rsti_pkg::CH_LX : rsti_pkg::CH_UX;
            5: return $urandom_range(1) ? rsti_pkg::CH_LB : rsti_pkg::CH_UB;
            6: return digit_char($urandom_range(35));
            7: return rsti_pkg::CH_9 + 8'd1;
            8: return rsti_pkg::CH_UA - 8'd1;
            default: return rsti_pkg::CH_LZ + 8'd1;
        endcase
    endfunction

    task automatic queue_char(logic [rsti_pkg::CHAR_BITS-1:0] code, logic has, logic lst);
        pending_chars.push_back(char_item_t'{code, has, lst});
        item_count++;
    endtask

    task automatic queue_string(input logic [rsti_pkg::CHAR_BITS-1:0] text[$]);
        int  i;
        bit  trailing_last;
        trailing_last = (text.size() == 0) || ($urandom_range(9) == 0);
        for (i = 0; i < text.size(); i++)
        begin
            if ($urandom_range(24) == 0)
                queue_char(8'($urandom), 1'b0, 1'b0);
            queue_char(text[i], 1'b1, !trailing_last && (i == text.size() - 1));
        end
        if (trailing_last)
            queue_char(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic gen_number();
        logic [rsti_pkg::CHAR_BITS-1:0] text[$];
        logic [63:0]                    mag;
        logic [63:0]                    base;
        int                             digits[$];
        int                             sel;
        int                             i;
        base = (conv_radix >= rsti_pkg::RADIX_MIN && conv_radix <= rsti_pkg::RADIX_MAX) ?
               64'(conv_radix) : 64'd10;
        if ($urandom_range(2) == 0)
            repeat ($urandom_range(1, 3)) text.push_back(pick_space());
        sel = $urandom_range(2);
        if (sel == 1)
            text.push_back(rsti_pkg::CH_PLUS);
        else if (sel == 2)
            text.push_back(rsti_pkg::CH_MINUS);
        if ((conv_radix == rsti_pkg::RADIX_HEX || conv_radix == rsti_pkg::RADIX_BIN)
            && $urandom_range(1) == 1)
        begin
            text.push_back(rsti_pkg::CH_0);
            if (conv_radix == rsti_pkg::RADIX_HEX)
                text.push_back($urandom_range(1) ? rsti_pkg::CH_LX : rsti_pkg::CH_UX);
            else
                text.push_back($urandom_range(1) ? rsti_pkg::CH_LB : rsti_pkg::CH_UB);
        end
        sel = $urandom_range(99);
        if (sel < 8)
            mag = POS_MAX;
        else if (sel < 16)
            mag = POS_MAX + 64'd1;
        else if (sel < 20)
            mag = $urandom_range(1) ? POS_MAX + 64'd2 : ~64'd0;
        else if (sel < 26)
            mag = 64'd0;
        else
            mag = {$urandom, $urandom} >> $urandom_range(63);
        while (mag != 64'd0)
        begin
            digits.push_front(int'(mag % base));
            mag = mag / base;
        end
        if (digits.size() == 0)
            digits.push_back(0);
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 2)) digits.push_front(0);
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 3)) digits.push_back($urandom_range(int'(base) - 1));
        for (i = 0; i < digits.size(); i++)
            text.push_back(digit_char(digits[i]));
        if ($urandom_range(5) == 0)
        begin
            text.push_back($urandom_range(1) ? pick_marked() : 8'($urandom));
            if ($urandom_range(1) == 1)
                text.push_back(digit_char($urandom_range(int'(base) - 1)));
        end
        queue_string(text);
    endtask

    task automatic gen_noise();
        logic [rsti_pkg::CHAR_BITS-1:0] text[$];
        repeat ($urandom_range(0, 6))
            text.push_back($urandom_range(1) ? pick_marked() : 8'($urandom));
        queue_string(text);
    endtask

    task automatic gen_broken();
        logic [rsti_pkg::CHAR_BITS-1:0] text[$];
        case ($urandom_range(3))
            0:
            begin
                text.push_back($urandom_range(1) ? rsti_pkg::CH_PLUS : rsti_pkg::CH_MINUS);
                text.push_back($urandom_range(1) ? rsti_pkg::CH_PLUS : rsti_pkg::CH_MINUS);
                text.push_back(digit_char($urandom_range(9)));
            end
            1:
            begin
                text.push_back(rsti_pkg::CH_MINUS);
                text.push_back(pick_space());
                text.push_back(digit_char($urandom_range(9)));
            end
            2:
            begin
                text.push_back(rsti_pkg::CH_0);
                text.push_back(pick_marked());
                repeat ($urandom_range(1, 3)) text.push_back(digit_char($urandom_range(15)));
            end
            default:
            begin
                text.push_back(digit_char($urandom_range(1)));
                text.push_back(pick_space());
                text.push_back(digit_char($urandom_range(1)));
            end
        endcase
        queue_string(text);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // hold the sender until every result has come, then let the block settle
    task automatic wait_idle();
        while (pending_chars.size() != 0 || char_ch.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_radix(logic [rsti_pkg::RADIX_BITS-1:0] r);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= r;
        @(posedge clk);
        cfg_we   <= 1'b0;
        conv_radix = r;
        @(negedge clk);
    endtask

    initial
    begin
        int p;
        int phase_start;
        int kind;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_data            = rsti_pkg::RADIX_RESET;
        conv_radix          = rsti_pkg::RADIX_RESET;
        clear_string();
        set_idling(25, 70);
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        queue_char(8'hFF, 1'b0, 1'b1);
        queue_char(rsti_pkg::CH_SPACE, 1'b1, 1'b0);
        queue_char(rsti_pkg::CH_TAB, 1'b1, 1'b0);
        queue_char(rsti_pkg::CH_LF, 1'b1, 1'b0);
        queue_char(rsti_pkg::CH_CR, 1'b1, 1'b0);
        queue_char(rsti_pkg::CH_MINUS, 1'b1, 1'b0);
        queue_char("9", 1'b1, 1'b0);
        queue_char(8'h00, 1'b1, 1'b1);
        queue_char(rsti_pkg::CH_PLUS, 1'b1, 1'b0);
        queue_char("a", 1'b1, 1'b1);
        queue_char("7", 1'b1, 1'b0);
        queue_char(8'h00, 1'b0, 1'b1);
        queue_char("8", 1'b1, 1'b0);
        queue_char(8'hFF, 1'b1, 1'b1);
        wait_idle();
        set_radix(rsti_pkg::RADIX_HEX);
        queue_char(rsti_pkg::CH_0, 1'b1, 1'b0);
        queue_char(rsti_pkg::CH_LX, 1'b1, 1'b1);
        queue_char(rsti_pkg::CH_MINUS, 1'b1, 1'b0);
        queue_char(rsti_pkg::CH_0, 1'b1, 1'b0);
        queue_char(rsti_pkg::CH_UX, 1'b1, 1'b0);
        queue_char("f", 1'b1, 1'b0);
        queue_char("F", 1'b1, 1'b1);
        wait_idle();
        set_radix(rsti_pkg::RADIX_BIN);
        queue_char(rsti_pkg::CH_0, 1'b1, 1'b0);
        queue_char(rsti_pkg::CH_UB, 1'b1, 1'b0);
        queue_char("1", 1'b1, 1'b1);
        wait_idle();
        set_radix(6'd0);
        queue_char("5", 1'b1, 1'b1);
        wait_idle();
        set_radix(6'd63);
        queue_char("1", 1'b1, 1'b1);
        wait_idle();
        set_radix(rsti_pkg::RADIX_MAX);
        queue_char(rsti_pkg::CH_UZ, 1'b1, 1'b0);
        queue_char(rsti_pkg::CH_LZ, 1'b1, 1'b1);

        for (p = 0; p < PHASES; p++)
        begin
            wait_idle();
            if (p == 5)
                set_idling(70, 25);
            else if (p == 10)
                set_idling(0, 0);
            set_radix((p == 11) ? 6'($urandom_range(3, 35)) : radix_plan[p]);
            phase_start = item_count;
            while (item_count - phase_start < ITEMS_PER_PHASE)
            begin
                kind = $urandom_range(99);
                if (kind < 70)
                    gen_number();
                else if (kind < 85)
                    gen_noise();
                else
                    gen_broken();
            end
        end

        wait_idle();
        if (error_count == 0)
            $display("radix_string_to_integer_core_tb: clean");
        else
            $display("radix_string_to_integer_core_tb: errors");
        $finish;
    end

endmodule
